[rtl/dctl_pkg.sv]
// Shared types, codes and constants for the distributed-clock time loop filter.
package dctl_pkg;

   // Time and field widths
   localparam int TIME_WIDTH_DEF = 64;
   localparam int FIELD_TIME_W   = 64;
   localparam int SLEW_W         = 15;
   localparam int SHIFT_W        = 4;
   localparam int DELAY_W        = 32;
   localparam int REPORT_W       = 32;
   localparam int MODE_W         = 2;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 32;

   // Register reset values and report limits
   localparam logic [SLEW_W-1:0]   SLEW_RESET  = 15'h1000;
   localparam logic [SHIFT_W-1:0]  SHIFT_RESET = 4'd4;
   localparam logic [DELAY_W-1:0]  DELAY_RESET = 32'd0;
   localparam logic [REPORT_W-2:0] MAG_MAX     = 31'h7FFF_FFFF;

   // Item modes
   typedef enum logic [MODE_W-1:0] {
      MODE_UPDATE       = 2'd0,
      MODE_RESET        = 2'd1,
      MODE_UPDATE_RESET = 2'd2,
      MODE_READ         = 2'd3
   } mode_type;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SLEW_BOUND  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_SHIFT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_DELAY  = 2'd2;

   // Configuration seen by the loop
   typedef struct packed {
      logic [SLEW_W-1:0]  slew_bound;
      logic [SHIFT_W-1:0] filter_shift;
      logic [DELAY_W-1:0] propagation_delay;
   } cfg_type;

endpackage

[rtl/dctl_csr.sv]
// Configuration registers of the time loop filter: slew bound, filter depth, delay.
module dctl_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dctl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dctl_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output dctl_pkg::cfg_type                  cfg
);
   import dctl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Always take a write; unknown indexes are dropped
   assign csr_ready = 1'b1;

   // Decode the write word into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SLEW_BOUND:   cfg_in.slew_bound        = csr_wdata[SLEW_W-1:0];
            CSR_FILTER_SHIFT: cfg_in.filter_shift      = csr_wdata[SHIFT_W-1:0];
            CSR_PROP_DELAY:   cfg_in.propagation_delay = csr_wdata[DELAY_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slew_bound        <= SLEW_RESET;
         cfg_ff.filter_shift      <= SHIFT_RESET;
         cfg_ff.propagation_delay <= DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/dctl_loop.sv]
// Loop state (correction, filtered difference, report) and its one-pass update.
module dctl_loop #(
   parameter int TIME_WIDTH = dctl_pkg::TIME_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dctl_pkg::cfg_type                  cfg,
   input  logic                               fire,
   input  logic [dctl_pkg::MODE_W-1:0]        mode,
   input  logic [dctl_pkg::FIELD_TIME_W-1:0]  local_time,
   input  logic [dctl_pkg::FIELD_TIME_W-1:0]  received_time,
   output logic [dctl_pkg::REPORT_W-1:0]      time_diff_raw,
   output logic [dctl_pkg::FIELD_TIME_W-1:0]  corrected_time
);
   import dctl_pkg::*;

   logic [TIME_WIDTH-1:0]   correction_ff,   correction_in;
   logic [63:0]             filtered_ff,     filtered_in;
   logic [REPORT_W-1:0]     report_ff,       report_in;

   logic                    do_update;
   logic                    do_clear;
   logic [TIME_WIDTH-1:0]   local_tw;
   logic [TIME_WIDTH-1:0]   dt_tw;
   logic signed [63:0]      dt;
   logic signed [63:0]      bound;
   logic [63:0]             step;
   logic [63:0]             err;
   logic [63:0]             err_mag;
   logic [63:0]             err_div;
   logic [63:0]             filt_upd;
   logic [63:0]             rep_mag;
   logic [REPORT_W-2:0]     rep_mag_sat;
   logic [REPORT_W-1:0]     rep_upd;
   logic [TIME_WIDTH-1:0]   corr_upd;
   logic [TIME_WIDTH-1:0]   corr_sum;

   // Decode mode
   always_comb begin
      do_update = 1'b0;
      do_clear  = 1'b0;
      unique case (mode)
         MODE_UPDATE:       do_update = 1'b1;
         MODE_RESET:        do_clear  = 1'b1;
         MODE_UPDATE_RESET: begin
            do_update = 1'b1;
            do_clear  = 1'b1;
         end
         MODE_READ:         do_update = 1'b0;
         default:           do_update = 1'b0;
      endcase
   end

   // Time error at time width, sign-extended to 64 bits
   assign local_tw = local_time[TIME_WIDTH-1:0];
   assign dt_tw    = local_tw + correction_ff - TIME_WIDTH'(cfg.propagation_delay)
                     - received_time[TIME_WIDTH-1:0];
   assign dt       = 64'($signed(dt_tw));

   // Clamp the correction step to plus or minus the slew bound
   assign bound = 64'(cfg.slew_bound);
   always_comb begin
      step = dt;
      if (dt > bound) begin
         step = bound;
      end else if (dt < -bound) begin
         step = -bound;
      end
   end
   assign corr_upd = correction_ff - step[TIME_WIDTH-1:0];

   // First-order filter, division truncated toward zero
   assign err     = dt - filtered_ff;
   assign err_mag = err[63] ? (64'd0 - err) : err;
   assign err_div = err_mag >> cfg.filter_shift;
   always_comb begin
      if (cfg.filter_shift == '0) begin
         filt_upd = dt;
      end else if (err[63]) begin
         filt_upd = filtered_ff - err_div;
      end else begin
         filt_upd = filtered_ff + err_div;
      end
   end

   // Sign-magnitude report with saturated magnitude
   assign rep_mag     = filt_upd[63] ? (64'd0 - filt_upd) : filt_upd;
   assign rep_mag_sat = (rep_mag[63:REPORT_W-1] != '0) ? MAG_MAX : rep_mag[REPORT_W-2:0];
   assign rep_upd     = {~filt_upd[63], rep_mag_sat};

   // Next state for this item
   always_comb begin
      correction_in = correction_ff;
      filtered_in   = filtered_ff;
      report_in     = report_ff;
      if (do_update) begin
         correction_in = corr_upd;
         filtered_in   = filt_upd;
         report_in     = rep_upd;
      end
      if (do_clear) begin
         filtered_in = '0;
         report_in   = '0;
      end
   end

   // Hold loop state; advance only when an item passes
   always_ff @(posedge clock) begin
      if (reset) begin
         correction_ff <= '0;
         filtered_ff   <= '0;
         report_ff     <= '0;
      end else if (fire) begin
         correction_ff <= correction_in;
         filtered_ff   <= filtered_in;
         report_ff     <= report_in;
      end
   end

   // Result of this item; wrap the corrected time at the time width
   assign corr_sum       = local_tw + correction_in;
   assign time_diff_raw  = report_in;
   assign corrected_time = FIELD_TIME_W'(corr_sum);

endmodule

[rtl/dc_time_loop_filter.sv]
// Top level of the distributed-clock time loop filter: input register, loop, result register.
//
// Distributed-clock time control loop. Each request word carries a mode, the local time
// (local clock plus system time offset) and, for updates, the received system time; each
// produces exactly one response word with the sign-magnitude filtered difference and the
// corrected local time. An accepted request word waits in the input register, then the loop
// update lands in the result register, from which the response word is taken. A new word
// is accepted every cycle unless req_stall is raised; the loop state (correction, filtered
// difference) updates in a single pass, so back-to-back updates see each other's result.
// Throughput drops only while the response side stalls. Configuration registers are
// written through the csr port (index 0 slew bound, 1 filter shift, 2 propagation delay)
// and should be changed only while no words are in flight.
module dc_time_loop_filter #(
   parameter int TIME_WIDTH = dctl_pkg::TIME_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [dctl_pkg::MODE_W-1:0]        req_mode,
   input  logic [dctl_pkg::FIELD_TIME_W-1:0]  req_local_time,
   input  logic [dctl_pkg::FIELD_TIME_W-1:0]  req_received_time,
   // response
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [dctl_pkg::REPORT_W-1:0]      rsp_time_diff_raw,
   output logic [dctl_pkg::FIELD_TIME_W-1:0]  rsp_corrected_time,
   // configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dctl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dctl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dctl_pkg::*;

   cfg_type                  cfg;

   logic                     in_valid_ff;
   logic [MODE_W-1:0]        in_mode_ff;
   logic [FIELD_TIME_W-1:0]  in_local_ff;
   logic [FIELD_TIME_W-1:0]  in_recv_ff;

   logic                     out_valid_ff;
   logic [REPORT_W-1:0]      out_diff_ff;
   logic [FIELD_TIME_W-1:0]  out_time_ff;

   logic                     out_open;
   logic                     fire;
   logic                     in_load;
   logic [REPORT_W-1:0]      res_diff;
   logic [FIELD_TIME_W-1:0]  res_time;

   dctl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake: result register frees when empty or taken; input register follows
   assign out_open  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_open;
   assign req_stall = in_valid_ff && !out_open;
   assign in_load   = req_valid && !req_stall;

   dctl_loop #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_loop (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .fire           (fire),
      .mode           (in_mode_ff),
      .local_time     (in_local_ff),
      .received_time  (in_recv_ff),
      .time_diff_raw  (res_diff),
      .corrected_time (res_time)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load || fire) begin
         in_valid_ff <= in_load;
      end
      if (in_load) begin
         in_mode_ff  <= req_mode;
         in_local_ff <= req_local_time;
         in_recv_ff  <= req_received_time;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_open) begin
         out_valid_ff <= fire;
      end
      if (fire) begin
         out_diff_ff <= res_diff;
         out_time_ff <= res_time;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_time_diff_raw  = out_diff_ff;
   assign rsp_corrected_time = out_time_ff;

endmodule

[sim/dc_time_loop_filter_checker.sv]
// Checker for the time loop filter: tracks the loop state and compares every response word.
`timescale 1ns / 100ps
module dc_time_loop_filter_checker #(
   parameter int TIME_WIDTH = dctl_pkg::TIME_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [dctl_pkg::MODE_W-1:0]        req_mode,
   input  logic [dctl_pkg::FIELD_TIME_W-1:0]  req_local_time,
   input  logic [dctl_pkg::FIELD_TIME_W-1:0]  req_received_time,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [dctl_pkg::REPORT_W-1:0]      rsp_time_diff_raw,
   input  logic [dctl_pkg::FIELD_TIME_W-1:0]  rsp_corrected_time,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [dctl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dctl_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                 error_count = 0,
   output int                                 pending_count = 0
);
   import dctl_pkg::*;

   localparam logic [63:0] TIME_MASK = {64{1'b1}} >> (64 - TIME_WIDTH);

   typedef struct packed {
      logic [REPORT_W-1:0]     diff_raw;
      logic [FIELD_TIME_W-1:0] corr_time;
   } loop_report_type;

   // Response words still owed by the block, oldest first
   loop_report_type expected_reports[$];

   // Loop settings as last written over the csr port
   logic [SLEW_W-1:0]   slew_bound;
   logic [SHIFT_W-1:0]  filter_shift;
   logic [DELAY_W-1:0]  prop_delay;

   // Loop state
   logic [63:0]         correction;
   logic [63:0]         filtered_diff;
   logic [REPORT_W-1:0] diff_report;
   int                  mismatches = 0;

   // Read a wrapped time difference as signed at the time width
   function automatic logic [63:0] wrap_signed(input logic [63:0] value);
      value &= TIME_MASK;
      if (value[TIME_WIDTH-1]) begin
         value |= ~TIME_MASK;
      end
      return value;
   endfunction

   // Advance the loop by one request word and return the response it should produce
   function automatic loop_report_type step_loop(input mode_type mode,
                                                 input logic [63:0] local_t,
                                                 input logic [63:0] recv_t);
      logic [63:0]     lt;
      logic [63:0]     dt;
      logic [63:0]     bound;
      logic [63:0]     slew_step;
      logic [63:0]     gap;
      logic [63:0]     share;
      logic [63:0]     mag;
      loop_report_type rep;
      lt = local_t & TIME_MASK;
      if (mode == MODE_UPDATE || mode == MODE_UPDATE_RESET) begin
         dt = wrap_signed(lt + correction - 64'(prop_delay) - recv_t);
         bound = 64'(slew_bound);
         // clamp the correction step to the slew bound
         slew_step = dt;
         if (!dt[63]) begin
            if (dt > bound) slew_step = bound;
         end else if ((64'd0 - dt) > bound) begin
            slew_step = 64'd0 - bound;
         end
         correction = (correction - slew_step) & TIME_MASK;
         // first-order filter, division truncated toward zero
         if (filter_shift == '0) begin
            filtered_diff = dt;
         end else begin
            gap = dt - filtered_diff;
            if (gap[63]) share = 64'd0 - ((64'd0 - gap) >> filter_shift);
            else share = gap >> filter_shift;
            filtered_diff = filtered_diff + share;
         end
         // sign-magnitude report with saturated magnitude
         mag = filtered_diff[63] ? (64'd0 - filtered_diff) : filtered_diff;
         if (mag > 64'(MAG_MAX)) mag = 64'(MAG_MAX);
         diff_report = {~filtered_diff[63], mag[REPORT_W-2:0]};
      end
      if (mode == MODE_RESET || mode == MODE_UPDATE_RESET) begin
         filtered_diff = '0;
         diff_report = '0;
      end
      rep.diff_raw = diff_report;
      rep.corr_time = (lt + correction) & TIME_MASK;
      return rep;
   endfunction

   // Watch all three channels: retire responses, track settings, predict requests
   always @(posedge clock) begin
      loop_report_type seen;
      loop_report_type want;
      if (reset) begin
         slew_bound = SLEW_RESET;
         filter_shift = SHIFT_RESET;
         prop_delay = DELAY_RESET;
         correction = '0;
         filtered_diff = '0;
         diff_report = '0;
         expected_reports.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.diff_raw = rsp_time_diff_raw;
            seen.corr_time = rsp_corrected_time;
            if (expected_reports.size() == 0) begin
               $error("response word with nothing outstanding: time_diff_raw %h corrected_time %h",
                      seen.diff_raw, seen.corr_time);
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               if (seen.diff_raw !== want.diff_raw) begin
                  $error("time_diff_raw: expected %h, got %h", want.diff_raw, seen.diff_raw);
                  mismatches++;
               end
               if (seen.corr_time !== want.corr_time) begin
                  $error("corrected_time: expected %h, got %h", want.corr_time, seen.corr_time);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SLEW_BOUND:   slew_bound = csr_wdata[SLEW_W-1:0];
               CSR_FILTER_SHIFT: filter_shift = csr_wdata[SHIFT_W-1:0];
               CSR_PROP_DELAY:   prop_delay = csr_wdata[DELAY_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_reports = {expected_reports,
                                step_loop(mode_type'(req_mode), req_local_time,
                                          req_received_time)};
         end
      end
      error_count <= mismatches;
      pending_count <= expected_reports.size();
   end

endmodule

[sim/dc_time_loop_filter_tb.sv]
// Testbench top for the time loop filter: clock, reset, stimulus, hold-offs and verdict.
`timescale 1ns / 100ps
module dc_time_loop_filter_tb;
   import dctl_pkg::*;

   localparam int PHASES       = 8;
   localparam int PHASE_WORDS  = 190;
   localparam int NO_IDLE_PHASE = 2;
   localparam int LOOP_LATENCY = 3;
   localparam int HOLD_CYCLES  = 200;
   localparam int QUIET_LIMIT  = 2000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [MODE_W-1:0]         req_mode = '0;
   logic [FIELD_TIME_W-1:0]   req_local_time = '0;
   logic [FIELD_TIME_W-1:0]   req_received_time = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [REPORT_W-1:0]       rsp_time_diff_raw;
   logic [FIELD_TIME_W-1:0]   rsp_corrected_time;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   int          check_errors;
   int          words_pending;
   int          req_idle_pct = 20;
   int          rsp_stall_pct = 20;
   int          hold_requests = 0;
   int          hold_served = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   int          words_sent = 0;
   int          settings_used = 1;
   int          drains = 0;
   logic [63:0] last_corrected = '0;
   logic [31:0] delay_now = '0;

   always #4 clock = ~clock;

   dc_time_loop_filter uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_local_time(req_local_time), .req_received_time(req_received_time),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_time_diff_raw(rsp_time_diff_raw),
      .rsp_corrected_time(rsp_corrected_time),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   dc_time_loop_filter_checker loop_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_local_time(req_local_time), .req_received_time(req_received_time),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_time_diff_raw(rsp_time_diff_raw),
      .rsp_corrected_time(rsp_corrected_time),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .error_count(check_errors), .pending_count(words_pending)
   );

   // Receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_served <= 0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Keep the last corrected time seen, used to aim corner differences
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) last_corrected <= rsp_corrected_time;
   end

   // Watchdog: end the run when no word moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("dc_time_loop_filter regression: fail");
            $finish;
         end
      end
   end

   // Offer one request word, with random idle cycles ahead of it
   task automatic send_word(input mode_type mode, input logic [63:0] local_t,
                            input logic [63:0] recv_t);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_local_time <= local_t;
      req_received_time <= recv_t;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // Stop offering and wait for every outstanding response word
   task automatic drain_words();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
      repeat (LOOP_LATENCY) @(posedge clock);
   endtask

   // Write one register; leaves the write valid high for a following write
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_loop(input logic [31:0] slew_w, input logic [31:0] shift_w,
                               input logic [31:0] delay_w);
      write_csr(CSR_SLEW_BOUND, slew_w);
      write_csr(CSR_FILTER_SHIFT, shift_w);
      write_csr(CSR_PROP_DELAY, delay_w);
      csr_valid <= 1'b0;
      delay_now = delay_w;
      settings_used++;
   endtask

   // Learn the correction with a read, then send an update with an exact time difference
   task automatic send_diff(input logic [63:0] dt);
      logic [63:0] recv_t;
      send_word(MODE_READ, '0, {$urandom, $urandom});
      drain_words();
      recv_t = {$urandom, $urandom};
      send_word(MODE_UPDATE, dt - last_corrected + 64'(delay_now) + recv_t, recv_t);
   endtask

   initial begin
      logic [63:0] corner_diffs [9];
      logic [63:0] frame_time;
      logic [63:0] master_offset;
      logic [63:0] recv_t;
      logic [31:0] draw;
      int          run_left;
      int          roll;
      bit          noise_run;
      mode_type    mode;

      corner_diffs = '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                       64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000,
                       64'hFFFF_FFFF_8000_0000, 64'h0000_0000_0000_7FFF,
                       64'h0000_0000_0000_8000, 64'hFFFF_FFFF_FFFF_8000,
                       64'hFFFF_FFFF_FFFF_8001};
      frame_time = {$urandom, $urandom};
      master_offset = '0;
      run_left = 0;
      noise_run = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset settings: every mode, time extremes
      send_word(MODE_READ, '0, '0);
      send_word(MODE_UPDATE, '0, '0);
      send_word(MODE_UPDATE, '1, '0);
      send_word(MODE_UPDATE, '0, '1);
      send_word(MODE_UPDATE_RESET, '1, '1);
      send_word(MODE_RESET, {$urandom, $urandom}, {$urandom, $urandom});
      send_word(MODE_READ, '1, {$urandom, $urandom});
      drain_words();

      // Unfiltered loop, widest slew, largest delay: aim at clamp and report limits,
      // including the most negative difference
      write_csr(CSR_SPARE, $urandom);
      program_loop(32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
      foreach (corner_diffs[i]) send_diff(corner_diffs[i]);

      // Random phases: runs of frames at a steady master offset, mixed with noise
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_words();
         if (phase == 0) program_loop(32'hFFFF_FFFF, 32'h0, $urandom);
         else if (phase == 1) program_loop(32'h0, 32'hF, 32'hFFFF_FFFF);
         else program_loop($urandom, $urandom,
                           ($urandom_range(3) == 0) ? $urandom : $urandom_range(100000));
         req_idle_pct = (phase == NO_IDLE_PHASE) ? 0 : 20;
         rsp_stall_pct <= (phase == NO_IDLE_PHASE) ? 0 : 20;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (run_left == 0) begin
               noise_run = ($urandom_range(4) == 0);
               run_left = noise_run ? $urandom_range(1, 3) : $urandom_range(8, 40);
               // drift the offset slightly, jump it, or throw it anywhere
               roll = $urandom_range(9);
               draw = $urandom;
               if (roll < 7) master_offset = master_offset + 64'($urandom_range(6000)) - 64'd3000;
               else if (roll < 9) master_offset = {{43{draw[20]}}, draw[20:0]};
               else master_offset = {$urandom, draw};
            end
            run_left--;
            if (noise_run) begin
               send_word(mode_type'(2'($urandom_range(3))), {$urandom, $urandom},
                         {$urandom, $urandom});
            end else begin
               frame_time = frame_time + 64'd1_000_000 + 64'($urandom_range(2000));
               recv_t = frame_time - 64'(delay_now) - master_offset
                        + 64'($urandom_range(400)) - 64'd200;
               roll = $urandom_range(99);
               if (roll < 75) mode = MODE_UPDATE;
               else if (roll < 85) mode = MODE_READ;
               else if (roll < 93) mode = MODE_UPDATE_RESET;
               else mode = MODE_RESET;
               send_word(mode, frame_time, recv_t);
            end
            // long receiver hold-off while the sender keeps offering
            if ((phase == 3 || phase == 6) && n == PHASE_WORDS / 2) begin
               hold_requests <= hold_requests + 1;
            end
            if ($urandom_range(149) == 0) begin
               drain_words();
               drains++;
            end
         end
      end
      drain_words();

      $display("Run covered %0d request words over %0d loop settings, corner differences",
               words_sent, settings_used);
      $display("at the slew and report limits, 2 long response hold-offs and %0d mid-run drains",
               drains);
      if (check_errors == 0) begin
         $display("dc_time_loop_filter regression: pass");
      end else begin
         $display("dc_time_loop_filter regression: fail");
      end
      $finish;
   end

endmodule
